// ===== rtl/core/tbrd_pkg.sv =====
package tbrd_pkg;

  // length register value after reset, in output bytes
  localparam logic [15:0] LenReset = 16'd960;

  // run lengths up to 39 bits fit in six bits
  localparam int unsigned RunW = 6;

  // kinds of entries passed from the decoder to the bit packer
  typedef enum logic [1:0] {
    ENT_RUN,
    ENT_ITEM_END,
    ENT_STREAM_END
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e     kind;
    logic            fill_bit;
    logic [RunW-1:0] run_len;
  } q_entry_t;

endpackage

// ===== rtl/core/two_bit_op_bit_run_decompressor_unit.sv =====
// Bit-run decompressor with two-bit opcodes.
// Input channel (in_valid_i / in_stall_o) takes one compressed byte per transaction,
// with stream_end_i marking the last byte of a stream. Output channel
// (out_valid_o / out_stall_i) gives one decompressed byte per transaction,
// final_byte_o set on the last byte of a stream. Config channel (cfg_valid_i /
// cfg_ready_o / cfg_data_i) writes the output length in bytes and restarts the stream.
// Rate: the decoder takes a byte, decodes its bits into queue entries, then pushes a
// boundary marker, and takes no new byte before that; a full queue holds it. A byte with
// stream_end_i also finishes the open command. The bit packer takes up to 8 bits of a run
// per cycle and one literal bit per cycle while the output is not stalled; the slower
// of the two sets the rate.
// Output: a finished byte is held until the next byte completes or its input
// transaction is closed, then moves to the output register.
// Reset: length is 960 bytes, decoder waits for an opcode, queue and output empty.
// A stalled receiver holds the output register; the packer and then the
// decoder back up through the 4-entry queue and in_stall_o rises.
module two_bit_op_bit_run_decompressor_unit #(
  parameter int MAX_OUTPUT_BYTES = 65535,
  parameter int FIFO_DEPTH       = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  compressed_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  output_byte_o,
  output logic        final_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int EffMax = (MAX_OUTPUT_BYTES > 65535) ? 65535 : MAX_OUTPUT_BYTES;
  localparam int BudgetW = $clog2(EffMax + 1);
  localparam int ResetBudget =
    (int'(tbrd_pkg::LenReset) > EffMax) ? EffMax : int'(tbrd_pkg::LenReset);
  localparam logic [15:0] LenCap = 16'(EffMax);

  logic               cfg_we;
  logic [15:0]        len_q;
  logic [15:0]        len_sel, len_clip;
  logic [BudgetW-1:0] reload;
  logic               q_push, q_full, q_pop, q_valid;
  tbrd_pkg::q_entry_t q_wdata, q_rdata;

  // length register
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= tbrd_pkg::LenReset;
    end else if (cfg_we) begin
      len_q <= cfg_data_i;
    end
  end

  // byte budget for the next stream
  assign len_sel  = cfg_we ? cfg_data_i : len_q;
  assign len_clip = (len_sel > LenCap) ? LenCap : len_sel;
  assign reload   = len_clip[BudgetW-1:0];

  tbrd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .restart_i         (cfg_we),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .compressed_byte_i (compressed_byte_i),
    .stream_end_i      (stream_end_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_entry_o         (q_wdata)
  );

  tbrd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (cfg_we),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  tbrd_back #(
    .BUDGET_W     (BudgetW),
    .RESET_BUDGET (ResetBudget)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (cfg_we),
    .reload_i      (reload),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .output_byte_o (output_byte_o),
    .final_byte_o  (final_byte_o)
  );

  // decoder never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue written while full");

  // packer never reads an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue read while empty");

  // an accepted byte keeps the decoder busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cfg_we) |=> in_stall_o)
    else $error("decoder idle right after accepting a byte");

endmodule

// ===== rtl/core/tbrd_front.sv =====
module tbrd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         compressed_byte_i,
  input  logic               stream_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tbrd_pkg::q_entry_t q_entry_o
);

  localparam logic [1:0] OpZeroRun = 2'b00;
  localparam logic [1:0] OpLit32   = 2'b01;
  localparam logic [1:0] OpFillRun = 2'b10;

  localparam logic [tbrd_pkg::RunW-1:0] ZeroRunBase = 6'd4;
  localparam logic [tbrd_pkg::RunW-1:0] FillRunBase = 6'd8;
  localparam logic [tbrd_pkg::RunW-1:0] Lit32Len    = 6'd32;
  localparam logic [tbrd_pkg::RunW-1:0] Lit4Len     = 6'd4;
  localparam logic [tbrd_pkg::RunW-1:0] CountMarker = 6'd1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_BITS,
    F_MARK,
    F_FLUSH
  } fstate_e;

  typedef enum logic [2:0] {
    PH_OP_HI,
    PH_OP_LO,
    PH_FILL,
    PH_COUNT,
    PH_LIT
  } phase_e;

  fstate_e                     fstate_q, fstate_d;
  phase_e                      phase_q, phase_d;
  logic [1:0]                  opcode_q, opcode_d;
  logic [tbrd_pkg::RunW-1:0]   fc_q, fc_d;
  logic                        fill_q, fill_d;
  logic [7:0]                  byte_q, byte_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic                        last_q, last_d;

  // single bit decode results
  logic                        dec_bit;
  phase_e                      dec_phase;
  logic [1:0]                  dec_opcode;
  logic [tbrd_pkg::RunW-1:0]   dec_fc;
  logic                        dec_fill;
  logic                        dec_push;
  tbrd_pkg::q_entry_t          dec_entry;
  logic [tbrd_pkg::RunW-1:0]   count_sh;

  // missing bits at stream end read as zero
  assign dec_bit = (fstate_q == F_BITS) ? byte_q[7] : 1'b0;

  // command decode of one stream bit
  always_comb begin
    dec_phase          = phase_q;
    dec_opcode         = opcode_q;
    dec_fc             = fc_q;
    dec_fill           = fill_q;
    dec_push           = 1'b0;
    dec_entry.kind     = tbrd_pkg::ENT_RUN;
    dec_entry.fill_bit = dec_bit;
    dec_entry.run_len  = 6'd1;
    count_sh           = {fc_q[4:0], dec_bit};
    case (phase_q)
      PH_OP_HI: begin
        dec_opcode = {dec_bit, 1'b0};
        dec_phase  = PH_OP_LO;
      end
      PH_OP_LO: begin
        dec_opcode = {opcode_q[1], dec_bit};
        case ({opcode_q[1], dec_bit})
          OpZeroRun: begin
            dec_fc    = CountMarker;
            dec_phase = PH_COUNT;
          end
          OpLit32: begin
            dec_fc    = Lit32Len;
            dec_phase = PH_LIT;
          end
          OpFillRun: begin
            dec_phase = PH_FILL;
          end
          default: begin
            dec_fc    = Lit4Len;
            dec_phase = PH_LIT;
          end
        endcase
      end
      PH_FILL: begin
        dec_fill  = dec_bit;
        dec_fc    = CountMarker;
        dec_phase = PH_COUNT;
      end
      PH_COUNT: begin
        // marker bit reaching the top ends the count field
        if (count_sh[5]) begin
          dec_push = 1'b1;
          if (opcode_q == OpZeroRun) begin
            dec_entry.fill_bit = 1'b0;
            dec_entry.run_len  = {1'b0, count_sh[4:0]} + ZeroRunBase;
          end else begin
            dec_entry.fill_bit = fill_q;
            dec_entry.run_len  = {1'b0, count_sh[4:0]} + FillRunBase;
          end
          dec_fc    = '0;
          dec_phase = PH_OP_HI;
        end else begin
          dec_fc = count_sh;
        end
      end
      PH_LIT: begin
        dec_push = 1'b1;
        if (fc_q <= 6'd1) begin
          dec_fc    = '0;
          dec_phase = PH_OP_HI;
        end else begin
          dec_fc = fc_q - 6'd1;
        end
      end
      default: begin
        dec_phase = PH_OP_HI;
      end
    endcase
  end

  // byte sequencing, boundary markers and end of stream completion
  always_comb begin
    fstate_d           = fstate_q;
    phase_d            = phase_q;
    opcode_d           = opcode_q;
    fc_d               = fc_q;
    fill_d             = fill_q;
    byte_d             = byte_q;
    cnt_d              = cnt_q;
    last_d             = last_q;
    q_push_o           = 1'b0;
    q_entry_o          = dec_entry;
    case (fstate_q)
      F_IDLE: begin
        if (in_valid_i) begin
          byte_d   = compressed_byte_i;
          last_d   = stream_end_i;
          cnt_d    = 3'd7;
          fstate_d = F_BITS;
        end
      end
      F_BITS: begin
        if (!q_full_i) begin
          q_push_o = dec_push;
          phase_d  = dec_phase;
          opcode_d = dec_opcode;
          fc_d     = dec_fc;
          fill_d   = dec_fill;
          byte_d   = {byte_q[6:0], 1'b0};
          cnt_d    = cnt_q - 3'd1;
          if (cnt_q == 3'd0) begin
            fstate_d = last_q ? F_FLUSH : F_MARK;
          end
        end
      end
      F_MARK: begin
        if (!q_full_i) begin
          q_push_o           = 1'b1;
          q_entry_o.kind     = tbrd_pkg::ENT_ITEM_END;
          q_entry_o.fill_bit = 1'b0;
          q_entry_o.run_len  = '0;
          fstate_d           = F_IDLE;
        end
      end
      F_FLUSH: begin
        if (!q_full_i) begin
          if (phase_q == PH_OP_HI) begin
            q_push_o           = 1'b1;
            q_entry_o.kind     = tbrd_pkg::ENT_STREAM_END;
            q_entry_o.fill_bit = 1'b0;
            q_entry_o.run_len  = '0;
            opcode_d           = '0;
            fc_d               = '0;
            fill_d             = 1'b0;
            fstate_d           = F_IDLE;
          end else if (phase_q == PH_LIT) begin
            // remaining literal bits are all zero: one run
            q_push_o           = 1'b1;
            q_entry_o.kind     = tbrd_pkg::ENT_RUN;
            q_entry_o.fill_bit = 1'b0;
            q_entry_o.run_len  = fc_q;
            fc_d               = '0;
            phase_d            = PH_OP_HI;
          end else begin
            q_push_o = dec_push;
            phase_d  = dec_phase;
            opcode_d = dec_opcode;
            fc_d     = dec_fc;
            fill_d   = dec_fill;
          end
        end
      end
      default: begin
        fstate_d = F_IDLE;
      end
    endcase
    // length write abandons the stream
    if (restart_i) begin
      fstate_d = F_IDLE;
      phase_d  = PH_OP_HI;
      opcode_d = '0;
      fc_d     = '0;
      fill_d   = 1'b0;
    end
  end

  assign in_stall_o = (fstate_q != F_IDLE);

  // state and decode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q <= F_IDLE;
      phase_q  <= PH_OP_HI;
      opcode_q <= '0;
      fc_q     <= '0;
      fill_q   <= 1'b0;
      byte_q   <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      fstate_q <= fstate_d;
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fc_q     <= fc_d;
      fill_q   <= fill_d;
      byte_q   <= byte_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
    end
  end

endmodule

// ===== rtl/core/tbrd_fifo.sv =====
module tbrd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  logic               push_i,
  input  tbrd_pkg::q_entry_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tbrd_pkg::q_entry_t rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tbrd_pkg::q_entry_t mem_q [DEPTH];
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/tbrd_back.sv =====
module tbrd_back #(
  parameter int BUDGET_W     = 16,
  parameter int RESET_BUDGET = 960
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [BUDGET_W-1:0] reload_i,
  input  logic                q_valid_i,
  input  tbrd_pkg::q_entry_t  q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          output_byte_o,
  output logic                final_byte_o
);

  logic [7:0]                shift_q, shift_d;
  logic [2:0]                obc_q, obc_d;
  logic [BUDGET_W-1:0]       budget_q, budget_d;
  logic [tbrd_pkg::RunW-1:0] run_left_q, run_left_d;
  logic                      run_bit_q, run_bit_d;
  logic                      hold_valid_q, hold_valid_d;
  logic [7:0]                hold_byte_q, hold_byte_d;
  logic                      hold_final_q, hold_final_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      out_final_q, out_final_d;

  logic                      active, done, out_free, head_run;
  logic [tbrd_pkg::RunW-1:0] cur_len;
  logic                      cur_bit;
  logic [3:0]                space, take;
  logic [3:0]                obc_sum;
  logic [15:0]               wide;
  logic [7:0]                pad_byte;

  assign active   = (run_left_q != '0);
  assign done     = (budget_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign head_run = q_valid_i && (q_entry_i.kind == tbrd_pkg::ENT_RUN);
  assign cur_len  = active ? run_left_q : q_entry_i.run_len;
  assign cur_bit  = active ? run_bit_q : q_entry_i.fill_bit;

  // bits that fit into the current byte this cycle
  assign space    = 4'd8 - {1'b0, obc_q};
  assign take     = (cur_len < {2'b00, space}) ? cur_len[3:0] : space;
  assign obc_sum  = {1'b0, obc_q} + take;
  assign wide     = {shift_q, {8{cur_bit}}} << take;
  assign pad_byte = 8'(shift_q << space);

  always_comb begin
    shift_d      = shift_q;
    obc_d        = obc_q;
    budget_d     = budget_q;
    run_left_d   = run_left_q;
    run_bit_d    = run_bit_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    hold_final_d = hold_final_q;
    out_byte_d   = out_byte_q;
    out_final_d  = out_final_q;
    out_valid_d  = out_stall_i ? out_valid_q : 1'b0;
    q_pop_o      = 1'b0;

    if (active || head_run) begin
      // run bits, at most one byte boundary per cycle
      if (done) begin
        run_left_d = '0;
        q_pop_o    = !active;
      end else if (obc_sum[3]) begin
        if (!hold_valid_q || out_free) begin
          if (hold_valid_q) begin
            out_valid_d = 1'b1;
            out_byte_d  = hold_byte_q;
            out_final_d = hold_final_q;
          end
          hold_valid_d = 1'b1;
          hold_byte_d  = wide[15:8];
          hold_final_d = (budget_q == BUDGET_W'(1));
          budget_d     = budget_q - BUDGET_W'(1);
          shift_d      = wide[15:8];
          obc_d        = '0;
          run_left_d   = cur_len - {2'b00, take};
          run_bit_d    = cur_bit;
          q_pop_o      = !active;
        end
      end else begin
        shift_d    = wide[15:8];
        obc_d      = obc_sum[2:0];
        run_left_d = cur_len - {2'b00, take};
        run_bit_d  = cur_bit;
        q_pop_o    = !active;
      end
    end else if (q_valid_i && q_entry_i.kind == tbrd_pkg::ENT_ITEM_END) begin
      // item transaction done: release the held byte
      if (!hold_valid_q) begin
        q_pop_o = 1'b1;
      end else if (out_free) begin
        out_valid_d  = 1'b1;
        out_byte_d   = hold_byte_q;
        out_final_d  = hold_final_q;
        hold_valid_d = 1'b0;
        q_pop_o      = 1'b1;
      end
    end else if (q_valid_i && q_entry_i.kind == tbrd_pkg::ENT_STREAM_END) begin
      if (!done && obc_q != '0) begin
        // release earlier byte, then park the padded partial byte
        if (hold_valid_q) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_byte_d   = hold_byte_q;
            out_final_d  = hold_final_q;
            hold_valid_d = 1'b0;
          end
        end else begin
          hold_valid_d = 1'b1;
          hold_byte_d  = pad_byte;
          hold_final_d = 1'b1;
          obc_d        = '0;
        end
      end else if (!hold_valid_q || out_free) begin
        if (hold_valid_q) begin
          out_valid_d = 1'b1;
          out_byte_d  = hold_byte_q;
          out_final_d = hold_final_q || !done;
        end
        q_pop_o      = 1'b1;
        hold_valid_d = 1'b0;
        obc_d        = '0;
        shift_d      = '0;
        run_left_d   = '0;
        budget_d     = reload_i;
      end
    end

    // length write abandons the stream
    if (restart_i) begin
      hold_valid_d = 1'b0;
      obc_d        = '0;
      shift_d      = '0;
      run_left_d   = '0;
      budget_d     = reload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      obc_q        <= '0;
      budget_q     <= BUDGET_W'(RESET_BUDGET);
      run_left_q   <= '0;
      run_bit_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      shift_q      <= shift_d;
      obc_q        <= obc_d;
      budget_q     <= budget_d;
      run_left_q   <= run_left_d;
      run_bit_q    <= run_bit_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_byte_q  <= hold_byte_d;
    hold_final_q <= hold_final_d;
    out_byte_q   <= out_byte_d;
    out_final_q  <= out_final_d;
  end

  assign out_valid_o   = out_valid_q;
  assign output_byte_o = out_byte_q;
  assign final_byte_o  = out_final_q;

endmodule

// ===== verif/two_bit_op_bit_run_decompressor_unit_tb.sv =====
module two_bit_op_bit_run_decompressor_unit_tb;

  // decoder phases of the expansion model
  typedef enum logic [2:0] {
    DEC_OP_HI,
    DEC_OP_LO,
    DEC_FILL,
    DEC_COUNT,
    DEC_LIT
  } dec_phase_e;

  // two-bit command codes
  localparam logic [1:0] OP_ZERO_RUN = 2'b00;
  localparam logic [1:0] OP_LIT32    = 2'b01;
  localparam logic [1:0] OP_FILL_RUN = 2'b10;
  localparam logic [1:0] OP_LIT4     = 2'b11;

  localparam int unsigned MaxStepBytes = 16;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned ItemTarget   = 300;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } out_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  comp_byte = 8'h00;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  output_byte;
  logic        final_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  two_bit_op_bit_run_decompressor_unit u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .compressed_byte_i (comp_byte),
    .stream_end_i      (stream_end),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .output_byte_o     (output_byte),
    .final_byte_o      (final_byte),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  always #4 clk = ~clk;

  // expansion model state
  logic [15:0] len_bytes;
  dec_phase_e  dec_phase;
  logic [1:0]  opcode;
  logic [5:0]  field_cnt;
  logic        fill_bit;
  logic [7:0]  pack_reg;
  int          pack_cnt;
  int          bits_left;
  logic        out_full;

  out_byte_t   step_bytes[$];
  out_byte_t   expected_bytes[$];
  comp_byte_t  pending_bytes[$];

  int  queued_cnt = 0;
  int  taken_cnt = 0;
  int  fail_cnt = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_started = 1'b0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  function automatic void restart_decode();
    dec_phase = DEC_OP_HI;
    opcode    = 2'b00;
    field_cnt = 6'd0;
    fill_bit  = 1'b0;
    pack_reg  = 8'h00;
    pack_cnt  = 0;
    bits_left = int'(len_bytes) * 8;
    out_full  = 1'b0;
  endfunction

  function automatic void add_step_byte(logic [7:0] data, logic fin);
    out_byte_t ob;
    ob.data = data;
    ob.fin  = fin;
    if (step_bytes.size() < MaxStepBytes) step_bytes.push_back(ob);
  endfunction

  function automatic void put_out_bit(logic b);
    if (bits_left == 0) begin
      out_full = 1'b1;
      return;
    end
    pack_reg = {pack_reg[6:0], b};
    pack_cnt++;
    bits_left--;
    if (pack_cnt == 8) begin
      add_step_byte(pack_reg, bits_left == 0);
      pack_reg = 8'h00;
      pack_cnt = 0;
    end
    if (bits_left == 0) out_full = 1'b1;
  endfunction

  function automatic void put_run(int run_len, logic b);
    for (int i = 0; i < run_len && !out_full; i++) put_out_bit(b);
  endfunction

  function automatic void take_bit(logic b);
    case (dec_phase)
      DEC_OP_LO: begin
        opcode = {opcode[1], b};
        case (opcode)
          OP_ZERO_RUN: begin
            field_cnt = 6'd1;
            dec_phase = DEC_COUNT;
          end
          OP_LIT32: begin
            field_cnt = 6'd32;
            dec_phase = DEC_LIT;
          end
          OP_FILL_RUN: dec_phase = DEC_FILL;
          default: begin
            field_cnt = 6'd4;
            dec_phase = DEC_LIT;
          end
        endcase
      end
      DEC_FILL: begin
        fill_bit  = b;
        field_cnt = 6'd1;
        dec_phase = DEC_COUNT;
      end
      DEC_COUNT: begin
        // a marker bit reaching the top means five count bits are in
        field_cnt = {field_cnt[4:0], b};
        if (field_cnt[5]) begin
          if (opcode == OP_ZERO_RUN) put_run(int'(field_cnt[4:0]) + 4, 1'b0);
          else put_run(int'(field_cnt[4:0]) + 8, fill_bit);
          field_cnt = 6'd0;
          dec_phase = DEC_OP_HI;
        end
      end
      DEC_LIT: begin
        put_out_bit(b);
        if (field_cnt > 0) field_cnt--;
        if (field_cnt == 0) dec_phase = DEC_OP_HI;
      end
      default: begin
        opcode    = {b, 1'b0};
        dec_phase = DEC_OP_LO;
      end
    endcase
  endfunction

  // expands one compressed byte into expected results
  function automatic void expand_byte(logic [7:0] data, logic last);
    step_bytes.delete();
    if (bits_left == 0) out_full = 1'b1;
    for (int i = 7; i >= 0 && !out_full; i--) take_bit(data[i]);
    if (last) begin
      // finish the open command with zero bits, then flush
      while (dec_phase != DEC_OP_HI && !out_full) take_bit(1'b0);
      if (!out_full) begin
        if (pack_cnt > 0) add_step_byte(pack_reg << (8 - pack_cnt), 1'b1);
        else if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].fin = 1'b1;
      end
      restart_decode();
    end
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endfunction

  // handshake monitor and result checker
  always @(posedge clk) begin : mon
    out_byte_t want;
    in_taken  <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
    if (out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output_byte %02h final_byte %0b", output_byte, final_byte);
        fail_cnt++;
      end else begin
        want = expected_bytes.pop_front();
        if (output_byte !== want.data) begin
          $error("output_byte expected %02h actual %02h", want.data, output_byte);
          fail_cnt++;
        end
        if (final_byte !== want.fin) begin
          $error("final_byte expected %0b actual %0b", want.fin, final_byte);
          fail_cnt++;
        end
      end
    end
    if (cfg_valid && cfg_ready) begin
      len_bytes = cfg_data;
      restart_decode();
    end
    if (in_valid && !in_stall) begin
      taken_cnt++;
      expand_byte(comp_byte, stream_end);
    end
  end

  // input driver
  always @(negedge clk) begin : drv
    comp_byte_t nxt;
    if (!in_valid || in_taken) begin
      if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        nxt = pending_bytes.pop_front();
        in_valid   <= 1'b1;
        comp_byte  <= nxt.data;
        stream_end <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HoldCycles;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("two_bit_op_bit_run_decompressor_unit verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_byte(logic [7:0] data, logic last);
    comp_byte_t cb;
    cb.data = data;
    cb.last = last;
    pending_bytes.push_back(cb);
    queued_cnt++;
  endtask

  // wait until every byte is taken and every result is back, then settle
  task automatic drain_all();
    while (taken_cnt != queued_cnt || expected_bytes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_length(logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  task automatic push_random_stream(int n_bytes, logic close_it);
    for (int k = 0; k < n_bytes; k++) begin
      push_byte(8'($urandom_range(0, 255)), close_it && (k == n_bytes - 1));
    end
  endtask

  initial begin
    int r;
    logic [15:0] new_len;
    len_bytes = 16'd960;
    restart_decode();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset length: zero runs and 32-bit literals, end inside a zero-run count
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hC3, 1'b1);
    drain_all();

    // one byte budget: output fills, remaining input ignored
    write_length(16'd1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    drain_all();

    // zero budget: nothing comes out
    write_length(16'd0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);
    drain_all();

    // largest budget: single-byte streams, end mid command
    write_length(16'hFFFF);
    push_byte(8'h80, 1'b1);
    push_byte(8'h05, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain_all();

    // receiver holds off while the sender keeps going
    write_length(16'd600);
    hold_req = 1'b1;
    push_random_stream(24, 1'b1);
    drain_all();

    // back-to-back stretch with no idling on either side
    write_length(16'd300);
    calm = 1'b1;
    push_random_stream(30, 1'b1);
    drain_all();
    calm = 1'b0;

    // random budgets and streams
    while (queued_cnt < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 25) new_len = 16'($urandom_range(1, 4));
      else if (r < 85) new_len = 16'($urandom_range(5, 48));
      else if (r < 97) new_len = 16'($urandom_range(49, 400));
      else new_len = 16'hFFFF;
      write_length(new_len);
      repeat ($urandom_range(1, 4)) begin
        push_random_stream($urandom_range(1, 10), $urandom_range(0, 9) != 0);
      end
      drain_all();
    end

    if (fail_cnt == 0) begin
      $display("two_bit_op_bit_run_decompressor_unit verification clean");
    end else begin
      $display("two_bit_op_bit_run_decompressor_unit verification failed");
    end
    $finish;
  end

endmodule
